FILE: rtl/srit_pkg.sv
`timescale 1ns / 1ps

package srit_pkg;

  localparam int unsigned CoordW  = 20;
  localparam int unsigned SizeW   = 19;
  localparam int unsigned DeltaW  = 21;
  localparam int unsigned DiffW   = 22;
  localparam int unsigned ProdW   = DeltaW + DiffW;
  localparam int unsigned OrientW = ProdW + 1;
  localparam int unsigned NumEdge = 4;

  typedef enum logic [1:0] {
    CFG_RECT_LEFT   = 2'd0,
    CFG_RECT_TOP    = 2'd1,
    CFG_RECT_WIDTH  = 2'd2,
    CFG_RECT_HEIGHT = 2'd3
  } cfg_idx_e;

  // rectangle side coordinate minus the endpoint coordinate
  typedef struct packed {
    logic signed [DiffW-1:0] left;
    logic signed [DiffW-1:0] right;
    logic signed [DiffW-1:0] top;
    logic signed [DiffW-1:0] bottom;
  } point_diff_t;

  // edges: 0 top, 1 right, 2 bottom, 3 left
  // corners: 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left
  // edge e runs from corner e to corner e+1
  typedef struct packed {
    logic               point_hit;
    logic [NumEdge-1:0] edge_split;
    logic [NumEdge-1:0] corner_box;
  } geom_flags_t;

endpackage

FILE: rtl/srit_geom_flags.sv
`timescale 1ns / 1ps

module srit_geom_flags (
  input  srit_pkg::point_diff_t a_i,
  input  srit_pkg::point_diff_t b_i,
  input  logic                  width_nz_i,
  input  logic                  height_nz_i,
  output srit_pkg::geom_flags_t flags_o
);

  logic a_lp, a_ln, a_lz, a_rp, a_rn, a_rz, a_tp, a_tn, a_tz, a_bp, a_bn, a_bz;
  logic b_lp, b_ln, b_lz, b_rp, b_rn, b_rz, b_tp, b_tn, b_tz, b_bp, b_bn, b_bz;
  logic a_inside, b_inside, a_on_edge, b_on_edge;
  logic box_l, box_r, box_t, box_b;

  assign a_lz = (a_i.left == '0);
  assign a_ln = a_i.left[srit_pkg::DiffW-1];
  assign a_lp = !a_ln && !a_lz;
  assign a_rz = (a_i.right == '0);
  assign a_rn = a_i.right[srit_pkg::DiffW-1];
  assign a_rp = !a_rn && !a_rz;
  assign a_tz = (a_i.top == '0);
  assign a_tn = a_i.top[srit_pkg::DiffW-1];
  assign a_tp = !a_tn && !a_tz;
  assign a_bz = (a_i.bottom == '0);
  assign a_bn = a_i.bottom[srit_pkg::DiffW-1];
  assign a_bp = !a_bn && !a_bz;

  assign b_lz = (b_i.left == '0);
  assign b_ln = b_i.left[srit_pkg::DiffW-1];
  assign b_lp = !b_ln && !b_lz;
  assign b_rz = (b_i.right == '0);
  assign b_rn = b_i.right[srit_pkg::DiffW-1];
  assign b_rp = !b_rn && !b_rz;
  assign b_tz = (b_i.top == '0);
  assign b_tn = b_i.top[srit_pkg::DiffW-1];
  assign b_tp = !b_tn && !b_tz;
  assign b_bz = (b_i.bottom == '0);
  assign b_bn = b_i.bottom[srit_pkg::DiffW-1];
  assign b_bp = !b_bn && !b_bz;

  // half-open point in rectangle
  assign a_inside = !a_lp && a_rp && !a_tp && a_bp;
  assign b_inside = !b_lp && b_rp && !b_tp && b_bp;

  // endpoint lying on one of the closed edges
  assign a_on_edge = (a_tz && !a_lp && !a_rn) || (a_bz && !a_lp && !a_rn) ||
                     (a_rz && !a_tp && !a_bn) || (a_lz && !a_tp && !a_bn);
  assign b_on_edge = (b_tz && !b_lp && !b_rn) || (b_bz && !b_lp && !b_rn) ||
                     (b_rz && !b_tp && !b_bn) || (b_lz && !b_tp && !b_bn);

  // corner coordinate within the segment bounding box, per axis
  assign box_l = !((a_lp && b_lp) || (a_ln && b_ln));
  assign box_r = !((a_rp && b_rp) || (a_rn && b_rn));
  assign box_t = !((a_tp && b_tp) || (a_tn && b_tn));
  assign box_b = !((a_bp && b_bp) || (a_bn && b_bn));

  always_comb begin
    flags_o.point_hit     = a_inside || b_inside || a_on_edge || b_on_edge;
    // endpoints strictly on opposite sides of the edge line
    flags_o.edge_split[0] = width_nz_i && ((a_tp && b_tn) || (a_tn && b_tp));
    flags_o.edge_split[1] = height_nz_i && ((a_rp && b_rn) || (a_rn && b_rp));
    flags_o.edge_split[2] = width_nz_i && ((a_bp && b_bn) || (a_bn && b_bp));
    flags_o.edge_split[3] = height_nz_i && ((a_lp && b_ln) || (a_ln && b_lp));
    flags_o.corner_box[0] = box_l && box_t;
    flags_o.corner_box[1] = box_r && box_t;
    flags_o.corner_box[2] = box_r && box_b;
    flags_o.corner_box[3] = box_l && box_b;
  end

endmodule

FILE: rtl/segment_rect_intersect_test.sv
`timescale 1ns / 1ps

// Segment versus axis-aligned rectangle hit test. Each input transaction is one segment
// in signed Q16.4 pixels; each output transaction is one hit flag, set when an endpoint
// lies inside the half-open rectangle or the segment touches or crosses any closed edge.
// The user must write the rectangle (left, top, width, height) through the cfg port
// only while no transaction is in flight; the block does not enforce it. Throughput is
// one segment per clock while the output is not stalled. Stages: differences, the four
// corner cross-product multiplies, orientation subtracts and final combine. Each stage
// holds its contents under back-pressure and empty stages fill behind a stalled output.
module segment_rect_intersect_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [srit_pkg::CoordW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [srit_pkg::CoordW-1:0]  start_x_i,
  input  logic signed [srit_pkg::CoordW-1:0]  start_y_i,
  input  logic signed [srit_pkg::CoordW-1:0]  end_x_i,
  input  logic signed [srit_pkg::CoordW-1:0]  end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o
);

  localparam int unsigned CW = srit_pkg::CoordW;
  localparam int unsigned SW = srit_pkg::SizeW;
  localparam int unsigned DW = srit_pkg::DiffW;
  localparam int unsigned EW = srit_pkg::DeltaW;

  logic signed [CW-1:0] rect_left_q, rect_top_q;
  logic [SW-1:0]        rect_width_q, rect_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q   <= '0;
      rect_top_q    <= '0;
      rect_width_q  <= '0;
      rect_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (srit_pkg::cfg_idx_e'(cfg_idx_i))
        srit_pkg::CFG_RECT_LEFT:   rect_left_q   <= cfg_data_i;
        srit_pkg::CFG_RECT_TOP:    rect_top_q    <= cfg_data_i;
        srit_pkg::CFG_RECT_WIDTH:  rect_width_q  <= cfg_data_i[SW-1:0];
        srit_pkg::CFG_RECT_HEIGHT: rect_height_q <= cfg_data_i[SW-1:0];
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its contents move on
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: segment deltas and side-minus-endpoint differences
  logic [DW-1:0] left_w, top_w, right_w, bottom_w;
  logic [DW-1:0] ax_w, ay_w, bx_w, by_w;
  logic signed [EW-1:0] dx_d, dy_d, dx_q, dy_q;
  srit_pkg::point_diff_t pa_d, pb_d, pa_q, pb_q;

  assign left_w   = {{(DW-CW){rect_left_q[CW-1]}}, rect_left_q};
  assign top_w    = {{(DW-CW){rect_top_q[CW-1]}}, rect_top_q};
  assign right_w  = left_w + {{(DW-SW){1'b0}}, rect_width_q};
  assign bottom_w = top_w + {{(DW-SW){1'b0}}, rect_height_q};
  assign ax_w     = {{(DW-CW){start_x_i[CW-1]}}, start_x_i};
  assign ay_w     = {{(DW-CW){start_y_i[CW-1]}}, start_y_i};
  assign bx_w     = {{(DW-CW){end_x_i[CW-1]}}, end_x_i};
  assign by_w     = {{(DW-CW){end_y_i[CW-1]}}, end_y_i};

  always_comb begin
    dx_d = EW'(bx_w - ax_w);
    dy_d = EW'(by_w - ay_w);
    pa_d.left   = left_w - ax_w;
    pa_d.right  = right_w - ax_w;
    pa_d.top    = top_w - ay_w;
    pa_d.bottom = bottom_w - ay_w;
    pb_d.left   = left_w - bx_w;
    pb_d.right  = right_w - bx_w;
    pb_d.top    = top_w - by_w;
    pb_d.bottom = bottom_w - by_w;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  // stage 2: the four cross-product terms and the axis-aligned edge flags
  logic signed [srit_pkg::ProdW-1:0] p_dx_top_q, p_dx_bot_q, p_dy_left_q, p_dy_right_q;
  srit_pkg::geom_flags_t geom_d, geom2_q, geom3_q;

  srit_geom_flags u_geom (
    .a_i         (pa_q),
    .b_i         (pb_q),
    .width_nz_i  (rect_width_q != '0),
    .height_nz_i (rect_height_q != '0),
    .flags_o     (geom_d)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p_dx_top_q   <= dx_q * pa_q.top;
      p_dx_bot_q   <= dx_q * pa_q.bottom;
      p_dy_left_q  <= dy_q * pa_q.left;
      p_dy_right_q <= dy_q * pa_q.right;
      geom2_q      <= geom_d;
    end
  end

  // stage 3: orientation of each corner against the segment line
  logic signed [srit_pkg::OrientW-1:0] orient [srit_pkg::NumEdge];
  logic [srit_pkg::NumEdge-1:0] oz_d, on_d, op_d, oz_q, on_q, op_q;

  assign orient[0] = p_dx_top_q - p_dy_left_q;
  assign orient[1] = p_dx_top_q - p_dy_right_q;
  assign orient[2] = p_dx_bot_q - p_dy_right_q;
  assign orient[3] = p_dx_bot_q - p_dy_left_q;

  always_comb begin
    for (int i = 0; i < srit_pkg::NumEdge; i++) begin
      oz_d[i] = (orient[i] == '0);
      on_d[i] = orient[i][srit_pkg::OrientW-1];
      op_d[i] = !oz_d[i] && !on_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      oz_q    <= oz_d;
      on_q    <= on_d;
      op_q    <= op_d;
      geom3_q <= geom2_q;
    end
  end

  // stage 4: combine into the hit flag
  logic [srit_pkg::NumEdge-1:0] op_next, on_next, cross_hit;
  logic hit_d, hit_q;

  assign op_next   = {op_q[0], op_q[srit_pkg::NumEdge-1:1]};
  assign on_next   = {on_q[0], on_q[srit_pkg::NumEdge-1:1]};
  assign cross_hit = ((op_q & on_next) | (on_q & op_next)) & geom3_q.edge_split;
  assign hit_d     = geom3_q.point_hit || (|cross_hit) || (|(oz_q & geom3_q.corner_box));

  always_ff @(posedge clk_i) begin
    if (en4) hit_q <= hit_d;
  end

  assign hit_o = hit_q;

endmodule
